// File: design/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

	localparam int ARENA_BYTES_DEF  = 256;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int MAX_BLOCKS_DEF   = 16;

	localparam int LEN_W  = 8;
	localparam int PORT_W = 8;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef struct packed {
		req_type_t             req_type;
		logic [LEN_W-1:0]      alloc_size;
		logic [PORT_W-1:0]     release_address;
	} in_t;

	typedef struct packed {
		logic [PORT_W-1:0]     payload_address;
		status_t               status;
	} out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_LIM,
		S_A_REUSE,
		S_A_GAP,
		S_INS_RD,
		S_INS_WR,
		S_F_CMP,
		S_R_RD,
		S_R_WR,
		S_DONE
	} state_t;

endpackage

// File: design/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
// Allocate: per block walked, a limit read, a reuse check and a gap check; on insert,
// entries shift up by a read and a write each. Free: one compare per block searched,
// then on unlink entries shift down by a read and a write each. A new request is
// taken only when idle; the walk and the shift share one table read port, the walk
// one gap compare. A result is registered when the sequencer is done and output is free.
// Reset: one empty block at address 0; other table entries stay unwritten until used.

module first_fit_block_allocator_top #(
	parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
	parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ffba_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output ffba_pkg::out_t out_data
);

	import ffba_pkg::*;

	logic busy;
	logic res_valid;
	logic out_free;
	out_t res;
	out_t out_q;
	logic out_valid_q;

	assign in_stall  = busy;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	ffba_ctrl #(
		.ARENA_BYTES  (ARENA_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_BLOCKS   (MAX_BLOCKS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && !busy),
		.req       (in_data),
		.busy      (busy),
		.res_valid (res_valid),
		.res_take  (out_free),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_q <= res;
		end
	end

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a request is in progress");

	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

	a_out_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data))
		else $error("stalled result changed");

endmodule

// File: design/ffba_table.sv
`timescale 1ns / 1ps

module ffba_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 8,
	parameter int LW    = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [AW-1:0]            wstart,
	input  logic [LW-1:0]            wlen,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [AW-1:0]            rstart,
	output logic [LW-1:0]            rlen
);

	logic [AW-1:0] start_mem [DEPTH];
	logic [LW-1:0] len_mem   [DEPTH];
	logic [AW-1:0] rstart_q;
	logic [LW-1:0] rlen_q;

	always_ff @(posedge clk) begin
		if (we) begin
			start_mem[waddr] <= wstart;
			len_mem[waddr]   <= wlen;
		end
		rstart_q <= start_mem[raddr];
		rlen_q   <= len_mem[raddr];
	end

	assign rstart = rstart_q;
	assign rlen   = rlen_q;

endmodule

// File: design/ffba_room.sv
`timescale 1ns / 1ps

module ffba_room #(
	parameter int CW = 10
) (
	input  logic [CW-1:0] from_addr,
	input  logic [CW-1:0] to_addr,
	input  logic [CW-1:0] need,
	output logic          fit
);

	logic [CW-1:0] span;

	assign span = to_addr - from_addr;
	assign fit  = (to_addr >= from_addr) && (span >= need);

endmodule

// File: design/ffba_ctrl.sv
`timescale 1ns / 1ps

module ffba_ctrl #(
	parameter int ARENA_BYTES  = 256,
	parameter int HEADER_BYTES = 16,
	parameter int MAX_BLOCKS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  ffba_pkg::in_t req,
	output logic         busy,
	output logic         res_valid,
	input  logic         res_take,
	output ffba_pkg::out_t res
);

	import ffba_pkg::*;

	localparam int IW   = $clog2(MAX_BLOCKS);
	localparam int CNTW = $clog2(MAX_BLOCKS + 1);
	localparam int AW   = $clog2(ARENA_BYTES);
	localparam int CW   = $clog2(ARENA_BYTES + 2 * HEADER_BYTES + 512);

	state_t state_q, state_d;

	logic [IW-1:0]    idx_q, idx_d;
	logic [IW-1:0]    k_q, k_d;
	logic [CNTW-1:0]  count_q, count_d;
	logic [LEN_W-1:0] len0_q, len0_d;
	logic [AW-1:0]    cur_start_q, cur_start_d;
	logic [LEN_W-1:0] cur_len_q, cur_len_d;
	logic [AW-1:0]    nxt_start_q, nxt_start_d;
	logic [LEN_W-1:0] nxt_len_q, nxt_len_d;
	logic [CW-1:0]    lim_q, lim_d;
	logic [AW-1:0]    new_start_q, new_start_d;
	in_t              req_q, req_d;
	out_t             res_q, res_d;

	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	logic [AW-1:0]    mem_wstart;
	logic [LEN_W-1:0] mem_wlen;
	logic [IW-1:0]    mem_raddr;
	logic [AW-1:0]    rd_start;
	logic [LEN_W-1:0] rd_len;

	logic [CW-1:0]    room_from, room_to, room_need;
	logic             room_fit;

	logic [CNTW-1:0]  idx_p1, k_p1;
	logic             has_next;
	logic [CW-1:0]    pay_addr, end_addr, free_addr, rel_w;

	ffba_table #(
		.DEPTH (MAX_BLOCKS),
		.AW    (AW),
		.LW    (LEN_W)
	) u_table (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wstart (mem_wstart),
		.wlen   (mem_wlen),
		.raddr  (mem_raddr),
		.rstart (rd_start),
		.rlen   (rd_len)
	);

	ffba_room #(
		.CW (CW)
	) u_room (
		.from_addr (room_from),
		.to_addr   (room_to),
		.need      (room_need),
		.fit       (room_fit)
	);

	assign idx_p1    = CNTW'(idx_q) + CNTW'(1);
	assign k_p1      = CNTW'(k_q) + CNTW'(1);
	assign has_next  = idx_p1 < count_q;
	assign pay_addr  = CW'(cur_start_q) + CW'(HEADER_BYTES);
	assign end_addr  = pay_addr + CW'(cur_len_q);
	assign rel_w     = CW'(req_q.release_address);
	assign free_addr = CW'(req.release_address) - CW'(HEADER_BYTES);

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= CNTW'(1);
			len0_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			len0_q  <= len0_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q       <= idx_d;
		k_q         <= k_d;
		cur_start_q <= cur_start_d;
		cur_len_q   <= cur_len_d;
		nxt_start_q <= nxt_start_d;
		nxt_len_q   <= nxt_len_d;
		lim_q       <= lim_d;
		new_start_q <= new_start_d;
		req_q       <= req_d;
		res_q       <= res_d;
	end

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		k_d         = k_q;
		count_d     = count_q;
		len0_d      = len0_q;
		cur_start_d = cur_start_q;
		cur_len_d   = cur_len_q;
		nxt_start_d = nxt_start_q;
		nxt_len_d   = nxt_len_q;
		lim_d       = lim_q;
		new_start_d = new_start_q;
		req_d       = req_q;
		res_d       = res_q;
		mem_we      = 1'b0;
		mem_waddr   = idx_q;
		mem_wstart  = cur_start_q;
		mem_wlen    = req_q.alloc_size;
		mem_raddr   = IW'(idx_p1);
		room_from   = pay_addr;
		room_to     = lim_q;
		room_need   = CW'(req_q.alloc_size);

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d                 = req;
					res_d.payload_address = '0;
					idx_d                 = '0;
					mem_raddr             = IW'(1);
					if (req.req_type == REQ_ALLOC) begin
						cur_start_d = '0;
						cur_len_d   = len0_q;
						state_d     = S_A_LIM;
					end else if (CW'(req.release_address) < CW'(HEADER_BYTES)) begin
						res_d.status = ST_NOTFOUND;
						state_d      = S_DONE;
					end else if (free_addr == '0) begin
						len0_d       = '0;
						res_d.status = ST_OK;
						state_d      = S_DONE;
					end else if (count_q > CNTW'(1)) begin
						idx_d   = IW'(1);
						state_d = S_F_CMP;
					end else begin
						res_d.status = ST_NOTFOUND;
						state_d      = S_DONE;
					end
				end
			end
			S_A_LIM: begin
				lim_d       = has_next ? CW'(rd_start) : CW'(ARENA_BYTES);
				nxt_start_d = rd_start;
				nxt_len_d   = rd_len;
				state_d     = S_A_REUSE;
			end
			S_A_REUSE: begin
				if (cur_len_q == '0 && room_fit) begin
					if (idx_q == '0) begin
						len0_d = req_q.alloc_size;
					end else begin
						mem_we = 1'b1;
					end
					res_d.payload_address = pay_addr[PORT_W-1:0];
					res_d.status          = ST_OK;
					state_d               = S_DONE;
				end else begin
					state_d = S_A_GAP;
				end
			end
			S_A_GAP: begin
				room_from = end_addr;
				room_need = CW'(req_q.alloc_size) + CW'(HEADER_BYTES);
				mem_raddr = IW'(idx_p1 + CNTW'(1));
				if (count_q < CNTW'(MAX_BLOCKS) && room_fit) begin
					new_start_d           = AW'(end_addr);
					res_d.payload_address = PORT_W'(end_addr + CW'(HEADER_BYTES));
					res_d.status          = ST_OK;
					k_d                   = IW'(count_q - CNTW'(1));
					state_d               = S_INS_RD;
				end else if (has_next) begin
					cur_start_d = nxt_start_q;
					cur_len_d   = nxt_len_q;
					idx_d       = IW'(idx_p1);
					state_d     = S_A_LIM;
				end else begin
					res_d.status = ST_NOSPACE;
					state_d      = S_DONE;
				end
			end
			S_INS_RD: begin
				mem_raddr = k_q;
				if (k_q > idx_q) begin
					state_d = S_INS_WR;
				end else begin
					mem_we     = 1'b1;
					mem_waddr  = IW'(idx_p1);
					mem_wstart = new_start_q;
					count_d    = count_q + CNTW'(1);
					state_d    = S_DONE;
				end
			end
			S_INS_WR: begin
				mem_we     = 1'b1;
				mem_waddr  = IW'(k_p1);
				mem_wstart = rd_start;
				mem_wlen   = rd_len;
				k_d        = k_q - IW'(1);
				state_d    = S_INS_RD;
			end
			S_F_CMP: begin
				if (CW'(rd_start) == rel_w - CW'(HEADER_BYTES)) begin
					k_d     = idx_q;
					state_d = S_R_RD;
				end else if (has_next) begin
					idx_d = IW'(idx_p1);
				end else begin
					res_d.status = ST_NOTFOUND;
					state_d      = S_DONE;
				end
			end
			S_R_RD: begin
				mem_raddr = IW'(k_p1);
				if (k_p1 < count_q) begin
					state_d = S_R_WR;
				end else begin
					count_d      = count_q - CNTW'(1);
					res_d.status = ST_OK;
					state_d      = S_DONE;
				end
			end
			S_R_WR: begin
				mem_we     = 1'b1;
				mem_waddr  = k_q;
				mem_wstart = rd_start;
				mem_wlen   = rd_len;
				k_d        = IW'(k_p1);
				state_d    = S_R_RD;
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CNTW'(MAX_BLOCKS))
		else $error("block count out of range");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		($past(state_q) == S_INS_RD || $past(state_q) == S_R_RD))
		else $error("block count changed outside insert or remove");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WR) |-> (count_q < CNTW'(MAX_BLOCKS)))
		else $error("insert shift with full table");

endmodule
